>>> hdl/tcw_pkg.sv
`default_nettype none
package tcw_pkg;

  localparam int DefColumns = 80;
  localparam int DefRows    = 25;

  localparam logic [7:0] CharNewline   = 8'd10;
  localparam logic [7:0] CharReturn    = 8'd13;
  localparam logic [7:0] CharBackspace = 8'd8;
  localparam logic [7:0] CharTab       = 8'd9;
  localparam logic [7:0] CharSpace     = 8'h20;

  localparam int TabStep = 4;
  localparam int TabMask = TabStep - 1;

  typedef struct packed {
    logic [7:0] attr;
    logic [7:0] ch;
  } cell_t;

  localparam cell_t BlankCell = '{attr: 8'h0F, ch: CharSpace};

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_SET   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  typedef enum logic {
    ASEL_CELL  = 1'b0,
    ASEL_AHEAD = 1'b1
  } addr_sel_e;

endpackage
`default_nettype wire

>>> hdl/tcw_in_if.sv
`default_nettype none
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] character;
  logic [7:0] attribute;
  logic [6:0] column;
  logic [4:0] line;

  modport source (output valid, mode, character, attribute, column, line, input ready);
  modport sink (input valid, mode, character, attribute, column, line, output ready);
endinterface
`default_nettype wire

>>> hdl/tcw_out_if.sv
`default_nettype none
interface tcw_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cursor_column;
  logic [4:0] cursor_line;
  logic [7:0] cell_character;
  logic [7:0] cell_attribute;
  logic       scrolled;

  modport source (output valid, cursor_column, cursor_line, cell_character, cell_attribute,
                  scrolled, input ready);
  modport sink (input valid, cursor_column, cursor_line, cell_character, cell_attribute,
                scrolled, output ready);
endinterface
`default_nettype wire

>>> hdl/tcw_cell_store.sv
`default_nettype none
module tcw_cell_store #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire tcw_pkg::cell_t  wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output tcw_pkg::cell_t       rd_data_o
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

>>> hdl/tcw_addr_unit.sv
`default_nettype none
module tcw_addr_unit #(
  parameter int COLUMNS = 80,
  parameter int AW      = 11,
  parameter int CW      = 7
) (
  input  wire tcw_pkg::addr_sel_e sel_i,
  input  wire logic [AW-1:0]      row_base_i,
  input  wire logic [CW-1:0]      col_i,
  input  wire logic [AW-1:0]      ptr_i,
  output logic      [AW:0]        sum_o
);
  import tcw_pkg::*;

  logic [AW-1:0] opnd_a;
  logic [AW-1:0] opnd_b;

  always_comb begin
    unique case (sel_i)
      ASEL_CELL: begin
        opnd_a = row_base_i;
        opnd_b = AW'(col_i);
      end
      ASEL_AHEAD: begin
        opnd_a = ptr_i;
        opnd_b = AW'(COLUMNS);
      end
      default: begin
        opnd_a = '0;
        opnd_b = '0;
      end
    endcase
  end

  assign sum_o = {1'b0, opnd_a} + {1'b0, opnd_b};

endmodule
`default_nettype wire

>>> hdl/text_mode_console_writer.sv
`default_nettype none
// Text console over a COLUMNS x ROWS store of 16-bit cells (character in the low byte, color in
// the high byte). One word is taken at a time and one result word comes back for it. Putting a
// character or setting the cursor goes through the acceptance of the word, a pass over the shared
// address adder and the cell memory, and the load of the output register. Reading a cell adds a
// registered memory read before that load. Clearing the screen writes one cell per cycle over the
// whole store. A character that scrolls the screen copies one cell per cycle through the memory's
// read and write ports and then blanks the last row. After reset the block blanks the whole store
// before it first raises ready. A result waiting in the output register does not stop the next
// word from being accepted, but that word cannot finish until the waiting result has been taken.
module text_mode_console_writer #(
  parameter int COLUMNS = tcw_pkg::DefColumns,
  parameter int ROWS    = tcw_pkg::DefRows
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tcw_in_if.sink     in_i,
  tcw_out_if.source  out_o
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] LastCell  = AW'(CELLS - 1);
  localparam logic [AW-1:0] ScrollEnd = AW'(CELLS - COLUMNS);
  localparam logic [CW-1:0] LastCol   = CW'(COLUMNS - 1);
  localparam logic [RW-1:0] LastRow   = RW'(ROWS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_DONE
  } state_e;

  state_e        state_q;
  logic          item_q;
  mode_e         mode_q;
  logic [7:0]    ch_q;
  logic [7:0]    attr_q;
  logic [6:0]    col_in_q;
  logic [4:0]    line_in_q;
  logic [CW-1:0] cur_col_q;
  logic [RW-1:0] cur_row_q;
  logic [AW-1:0] ptr_q;
  logic [AW-1:0] wptr_q;
  logic [7:0]    rd_ch_q;
  logic [7:0]    rd_attr_q;
  logic          scrolled_q;
  logic          out_valid_q;
  logic [6:0]    out_col_q;
  logic [4:0]    out_row_q;
  logic [7:0]    out_ch_q;
  logic [7:0]    out_attr_q;
  logic          out_scr_q;
  logic          out_load;

  logic [CW+6:0] col_ext;
  logic [RW+4:0] line_ext;
  logic [CW+6:0] cur_col_ext;
  logic [RW+4:0] cur_row_ext;
  logic [CW-1:0] col_fit;
  logic [RW-1:0] line_fit;
  logic          col_ok;
  logic          line_ok;
  logic          read_ok;

  logic [CW:0]   col_wide;
  logic [CW:0]   nc;
  logic          row_inc;
  logic          put_wr;
  logic          put_back;
  logic [7:0]    put_ch;
  logic [RW:0]   row_next;
  logic          do_scroll;

  logic [RW-1:0] row_sel;
  logic [AW-1:0] row_base;
  logic [CW-1:0] col_opnd;
  addr_sel_e     addr_sel;
  logic [AW:0]   addr_sum;

  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  cell_t         mem_wr_data;
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  cell_t         mem_rd_data;

  assign col_ext     = {{CW{1'b0}}, col_in_q};
  assign line_ext    = {{RW{1'b0}}, line_in_q};
  assign cur_col_ext = {7'b0, cur_col_q};
  assign cur_row_ext = {5'b0, cur_row_q};
  assign col_fit     = col_ext[CW-1:0];
  assign line_fit    = line_ext[RW-1:0];
  assign col_ok      = int'(col_in_q) < COLUMNS;
  assign line_ok     = int'(line_in_q) < ROWS;
  assign read_ok     = col_ok && line_ok;

  assign col_wide = (CW+1)'(cur_col_q);

  always_comb begin
    nc       = col_wide;
    row_inc  = 1'b0;
    put_wr   = 1'b0;
    put_back = 1'b0;
    put_ch   = ch_q;
    case (ch_q)
      CharNewline: begin
        nc      = '0;
        row_inc = 1'b1;
      end
      CharReturn: begin
        nc = '0;
      end
      CharBackspace: begin
        if (cur_col_q != '0) begin
          nc       = col_wide - 1'b1;
          put_wr   = 1'b1;
          put_back = 1'b1;
          put_ch   = CharSpace;
        end
      end
      CharTab: begin
        nc = (col_wide + (CW+1)'(TabStep)) & ~((CW+1)'(TabMask));
      end
      default: begin
        put_wr = 1'b1;
        nc     = col_wide + 1'b1;
      end
    endcase
    if (int'(nc) >= COLUMNS) begin
      nc      = '0;
      row_inc = 1'b1;
    end
  end

  assign row_next  = (RW+1)'(cur_row_q) + (RW+1)'(row_inc);
  assign do_scroll = int'(row_next) >= ROWS;

  assign row_sel  = (mode_q == MODE_READ) ? line_fit : cur_row_q;
  assign row_base = AW'(row_sel * COLUMNS);
  assign col_opnd = (mode_q == MODE_READ) ? col_fit : (put_back ? nc[CW-1:0] : cur_col_q);
  assign addr_sel = (state_q == S_SCROLL) ? ASEL_AHEAD : ASEL_CELL;

  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .AW      (AW),
    .CW      (CW)
  ) u_addr (
    .sel_i      (addr_sel),
    .row_base_i (row_base),
    .col_i      (col_opnd),
    .ptr_i      (ptr_q),
    .sum_o      (addr_sum)
  );

  always_comb begin
    mem_wr_en   = 1'b0;
    mem_wr_addr = addr_sum[AW-1:0];
    mem_wr_data = '{attr: attr_q, ch: put_ch};
    mem_rd_en   = 1'b0;
    mem_rd_addr = addr_sum[AW-1:0];
    unique case (state_q)
      S_EXEC: begin
        mem_wr_en = (mode_q == MODE_PUT) && put_wr;
        mem_rd_en = (mode_q == MODE_READ) && read_ok;
      end
      S_SCROLL: begin
        mem_rd_en   = ptr_q != ScrollEnd;
        mem_wr_en   = ptr_q != '0;
        mem_wr_addr = wptr_q;
        mem_wr_data = mem_rd_data;
      end
      S_FILL: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr_q;
        mem_wr_data = BlankCell;
      end
      default: begin
        mem_wr_en = 1'b0;
        mem_rd_en = 1'b0;
      end
    endcase
  end

  tcw_cell_store #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FILL;
      item_q      <= 1'b0;
      mode_q      <= MODE_PUT;
      ch_q        <= '0;
      attr_q      <= '0;
      col_in_q    <= '0;
      line_in_q   <= '0;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      ptr_q       <= '0;
      wptr_q      <= '0;
      rd_ch_q     <= '0;
      rd_attr_q   <= '0;
      scrolled_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_ch_q    <= '0;
      out_attr_q  <= '0;
      out_scr_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            mode_q    <= mode_e'(in_i.mode);
            ch_q      <= in_i.character;
            attr_q    <= in_i.attribute;
            col_in_q  <= in_i.column;
            line_in_q <= in_i.line;
            item_q    <= 1'b1;
            state_q   <= S_EXEC;
          end
        end
        S_EXEC: begin
          rd_ch_q    <= '0;
          rd_attr_q  <= '0;
          scrolled_q <= 1'b0;
          unique case (mode_q)
            MODE_PUT: begin
              cur_col_q  <= nc[CW-1:0];
              cur_row_q  <= do_scroll ? LastRow : row_next[RW-1:0];
              scrolled_q <= do_scroll;
              ptr_q      <= '0;
              state_q    <= do_scroll ? S_SCROLL : S_DONE;
            end
            MODE_SET: begin
              cur_col_q <= col_ok ? col_fit : LastCol;
              cur_row_q <= line_ok ? line_fit : LastRow;
              state_q   <= S_DONE;
            end
            MODE_CLEAR: begin
              cur_col_q <= '0;
              cur_row_q <= '0;
              ptr_q     <= '0;
              state_q   <= S_FILL;
            end
            MODE_READ: begin
              state_q <= read_ok ? S_READ : S_DONE;
            end
            default: begin
              state_q <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          rd_ch_q   <= mem_rd_data.ch;
          rd_attr_q <= mem_rd_data.attr;
          state_q   <= S_DONE;
        end
        S_SCROLL: begin
          wptr_q <= ptr_q;
          if (ptr_q == ScrollEnd) begin
            state_q <= S_FILL;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_FILL: begin
          if (ptr_q == LastCell) begin
            state_q <= item_q ? S_DONE : S_IDLE;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_col_q   <= cur_col_ext[6:0];
            out_row_q   <= cur_row_ext[4:0];
            out_ch_q    <= rd_ch_q;
            out_attr_q  <= rd_attr_q;
            out_scr_q   <= scrolled_q;
            item_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready           = state_q == S_IDLE;
  assign out_o.valid          = out_valid_q;
  assign out_o.cursor_column  = out_col_q;
  assign out_o.cursor_line    = out_row_q;
  assign out_o.cell_character = out_ch_q;
  assign out_o.cell_attribute = out_attr_q;
  assign out_o.scrolled       = out_scr_q;

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_wr_en |-> int'(mem_wr_addr) < CELLS)
    else $error("Cell write outside the screen store.");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_col_q) < COLUMNS && int'(cur_row_q) < ROWS)
    else $error("Cursor left the screen.");

  a_scroll_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCROLL |-> scrolled_q && mode_q == MODE_PUT)
    else $error("Scroll pass without a scrolling put.");

  a_scroll_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_scr_q |-> out_ch_q == 8'd0 && out_attr_q == 8'd0)
    else $error("Scrolled word carries cell data.");

endmodule
`default_nettype wire
